[sv/cba_pkg.sv]
// Shared types and codes of the contiguous block allocator.
package cba_pkg;

	localparam int SIZE_W   = 24;
	localparam int BYTES_W  = 16;
	localparam int ID_W     = 16;
	localparam int NEED_W   = SIZE_W + 1;
	localparam int STATUS_W = 3;

	localparam logic CMD_CREATE = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_CREATED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DELETED    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

	localparam logic [15:0] BLOCK_BYTES_RST   = 16'd512;
	localparam logic [8:0]  BLOCKS_IN_USE_RST = 9'd256;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MARK,
		S_TWR,
		S_FIND_RD,
		S_FIND_CHK,
		S_FREE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic               start;
		logic [SIZE_W-1:0]  dividend;
		logic [BYTES_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [SIZE_W-1:0] quotient;
		logic              rem_nz;
	} div_rsp_t;

endpackage

[sv/cba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/cba_divider.sv]
// Restoring divider, one quotient bit per cycle, for rounding sizes up to blocks.
module cba_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  cba_pkg::div_req_t req,
	output cba_pkg::div_rsp_t rsp
);
	import cba_pkg::*;

	localparam int CNT_W = $clog2(SIZE_W + 1);

	logic [BYTES_W:0]   rem_q;
	logic [SIZE_W-1:0]  quo_q;
	logic [BYTES_W-1:0] dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [BYTES_W:0]   trial;
	logic [BYTES_W:0]   diff;

	assign trial = {rem_q[BYTES_W-1:0], quo_q[SIZE_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SIZE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[BYTES_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[SIZE_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[SIZE_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.rem_nz   = (rem_q != '0);

endmodule

[sv/contiguous_block_allocator.sv]
// Top level of the first-fit contiguous block allocator.
//
// Requests arrive on the in channel (in_valid/in_ready) with command, file_id
// and size_bytes. Each request produces exactly one result on the out channel
// (out_valid/out_ready) with status, start_block and length_blocks.
// The block works on one request at a time and holds in_ready low meanwhile,
// and also while its last result still waits on the out channel.
// A create first divides the size in the restoring divider, then scans the
// block map one block at a time (one read port of the block map RAM), marks
// the blocks of the run found and writes a table entry. A delete searches
// the table entry by entry, frees the blocks of the entry found and moves
// each later entry down one place to close the gap.
// After reset a clearing pass zeroes the block map one block at a time, and
// no request is taken until it ends; configuration writes are taken anytime.
// A finished result sits in an output register; if the receiver stalls, the
// block keeps it there and waits before taking the next request.
// Registers: block_bytes at 0x0 (reset 512), blocks_in_use at 0x4 (reset 256).
module contiguous_block_allocator #(
	parameter int MAP_BLOCKS    = 256,
	parameter int TABLE_ENTRIES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [15:0] file_id,
	input  logic [23:0] size_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  start_block,
	output logic [8:0]  length_blocks
);
	import cba_pkg::*;

	// Map address, block count, table address and entry count widths.
	localparam int MW  = $clog2(MAP_BLOCKS);
	localparam int LW  = $clog2(MAP_BLOCKS + 1);
	localparam int TW  = $clog2(TABLE_ENTRIES);
	localparam int CTW = $clog2(TABLE_ENTRIES + 1);
	localparam int EW  = ID_W + MW + LW;

	// Configuration registers, written on the access phase of an APB write.
	logic [15:0] block_bytes_q;
	logic [8:0]  blocks_in_use_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q   <= BLOCK_BYTES_RST;
			blocks_in_use_q <= BLOCKS_IN_USE_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				blocks_in_use_q <= pwdata[8:0];
			end else begin
				block_bytes_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = paddr[2] ? {23'd0, blocks_in_use_q} : {16'd0, block_bytes_q};

	// A zero block size counts as one byte per block, and the usable part of
	// the map is capped at the map size.
	logic [15:0]       bb_eff;
	logic [NEED_W-1:0] limit;

	assign bb_eff = (block_bytes_q == '0) ? 16'd1 : block_bytes_q;
	assign limit  = (NEED_W'(blocks_in_use_q) > NEED_W'(MAP_BLOCKS)) ?
		NEED_W'(MAP_BLOCKS) : NEED_W'(blocks_in_use_q);

	state_t state_q, state_d;

	logic              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [LW-1:0]     idx_q;
	logic [LW-1:0]     run_q;
	logic [MW-1:0]     first_q;
	logic [NEED_W-1:0] need_q;
	logic [CTW-1:0]    tidx_q;
	logic [CTW-1:0]    count_q;
	logic [MW-1:0]     ent_start_q;
	logic [LW-1:0]     ent_len_q;
	logic              out_valid_q;
	logic [2:0]        res_status_q;
	logic [MW-1:0]     res_start_q;
	logic [LW-1:0]     res_len_q;

	// Divider that rounds the byte size up to blocks.
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [NEED_W-1:0] need_calc;

	assign div_req.start    = in_valid && in_ready && (command == CMD_CREATE) &&
		(count_q < CTW'(TABLE_ENTRIES));
	assign div_req.dividend = size_bytes;
	assign div_req.divisor  = bb_eff;

	cba_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign need_calc = NEED_W'(div_rsp.quotient) + NEED_W'(div_rsp.rem_nz);

	// Block map: one busy bit per block.
	logic          map_we;
	logic [MW-1:0] map_waddr;
	logic          map_wdata;
	logic [MW-1:0] map_raddr;
	logic          map_rdata;

	cba_ram #(.WIDTH(1), .DEPTH(MAP_BLOCKS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// File table: {id, start, length} per entry, kept in creation order.
	logic          tab_we;
	logic [TW-1:0] tab_waddr;
	logic [EW-1:0] tab_wdata;
	logic [TW-1:0] tab_raddr;
	logic [EW-1:0] tab_rdata;

	cba_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_tab (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	logic [ID_W-1:0] rd_id;
	logic [MW-1:0]   rd_start;
	logic [LW-1:0]   rd_len;
	logic [LW:0]     run_inc;
	logic [MW-1:0]   first_new;

	assign rd_id     = tab_rdata[EW-1 -: ID_W];
	assign rd_start  = tab_rdata[LW +: MW];
	assign rd_len    = tab_rdata[LW-1:0];
	assign run_inc   = {1'b0, run_q} + 1'b1;
	assign first_new = (run_q == '0) ? idx_q[MW-1:0] : first_q;

	// A new request is taken only once the previous result has left.
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;

	// Next state and memory controls.
	always_comb begin
		state_d   = state_q;
		map_we    = 1'b0;
		map_waddr = idx_q[MW-1:0];
		map_wdata = 1'b0;
		map_raddr = idx_q[MW-1:0];
		tab_we    = 1'b0;
		tab_waddr = tidx_q[TW-1:0];
		tab_wdata = tab_rdata;
		tab_raddr = tidx_q[TW-1:0];
		case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
				if (idx_q == LW'(MAP_BLOCKS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					if (command == CMD_DELETE) begin
						state_d = S_FIND_RD;
					end else if (count_q < CTW'(TABLE_ENTRIES)) begin
						state_d = S_DIV;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					if (need_calc == '0 || need_calc > limit) begin
						state_d = S_RESP;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: begin
				if (NEED_W'(idx_q) == limit) begin
					state_d = S_RESP;
				end else begin
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (!map_rdata && NEED_W'(run_inc) == need_q) begin
					state_d = S_MARK;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_MARK: begin
				map_we    = 1'b1;
				map_wdata = 1'b1;
				if (run_q == LW'(1)) begin
					state_d = S_TWR;
				end
			end
			S_TWR: begin
				tab_we    = 1'b1;
				tab_waddr = count_q[TW-1:0];
				tab_wdata = {id_q, first_q, need_q[LW-1:0]};
				state_d   = S_RESP;
			end
			S_FIND_RD: begin
				if (tidx_q == count_q) begin
					state_d = S_RESP;
				end else begin
					state_d = S_FIND_CHK;
				end
			end
			S_FIND_CHK: begin
				if (rd_id == id_q) begin
					state_d = S_FREE;
				end else begin
					state_d = S_FIND_RD;
				end
			end
			S_FREE: begin
				map_we = 1'b1;
				if (run_q == LW'(1)) begin
					state_d = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				tab_raddr = TW'(tidx_q + 1'b1);
				if ((tidx_q + 1'b1) >= count_q) begin
					state_d = S_RESP;
				end else begin
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				tab_we  = 1'b1;
				state_d = S_SHIFT_RD;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RESP) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: idx_q <= idx_q + 1'b1;
				S_DIV: idx_q <= '0;
				S_SCAN_CHK: begin
					if (!map_rdata && NEED_W'(run_inc) == need_q) begin
						idx_q <= LW'(first_new);
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_MARK: idx_q <= idx_q + 1'b1;
				S_TWR: count_q <= count_q + 1'b1;
				S_FIND_CHK: idx_q <= LW'(rd_start);
				S_FREE: idx_q <= idx_q + 1'b1;
				S_SHIFT_RD: begin
					if ((tidx_q + 1'b1) >= count_q) begin
						count_q <= count_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers; they carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd_q        <= command;
					id_q         <= file_id;
					tidx_q       <= '0;
					res_status_q <= ST_TABLE_FULL;
					res_start_q  <= '0;
					res_len_q    <= '0;
				end
			end
			S_DIV: begin
				need_q       <= need_calc;
				run_q        <= '0;
				res_status_q <= ST_NO_SPACE;
			end
			S_SCAN_CHK: begin
				if (map_rdata) begin
					run_q <= '0;
				end else if (NEED_W'(run_inc) == need_q) begin
					first_q <= first_new;
					run_q   <= need_q[LW-1:0];
				end else begin
					first_q <= first_new;
					run_q   <= run_inc[LW-1:0];
				end
			end
			S_MARK: run_q <= run_q - 1'b1;
			S_TWR: begin
				res_status_q <= ST_CREATED;
				res_start_q  <= first_q;
				res_len_q    <= need_q[LW-1:0];
			end
			S_FIND_RD: begin
				res_status_q <= ST_NOT_FOUND;
			end
			S_FIND_CHK: begin
				if (rd_id == id_q) begin
					ent_start_q <= rd_start;
					ent_len_q   <= rd_len;
					run_q       <= rd_len;
				end else begin
					tidx_q <= tidx_q + 1'b1;
				end
			end
			S_FREE: run_q <= run_q - 1'b1;
			S_SHIFT_RD: begin
				res_status_q <= ST_DELETED;
				res_start_q  <= ent_start_q;
				res_len_q    <= ent_len_q;
			end
			S_SHIFT_WR: tidx_q <= tidx_q + 1'b1;
			default: begin
			end
		endcase
	end

	logic [31:0] start_ext;
	logic [31:0] len_ext;

	assign start_ext     = 32'(res_start_q);
	assign len_ext       = 32'(res_len_q);
	assign out_valid     = out_valid_q;
	assign status        = res_status_q;
	assign start_block   = start_ext[7:0];
	assign length_blocks = len_ext[8:0];

	// The table never holds more entries than it has room for.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CTW'(TABLE_ENTRIES))
		else $error("entry count above table size");

	// The entry count moves by at most one per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1))
		else $error("entry count jumped");

	// A taken request closes the input until its result is produced.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while busy");

	// A created file always occupies at least one block.
	a_created_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_status_q == ST_CREATED) |-> (res_len_q != '0))
		else $error("created file with zero length");

	// A create that reaches the table write came from a request of that kind.
	a_twr_create: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TWR) |-> (cmd_q == CMD_CREATE))
		else $error("table write outside a create");

endmodule
